/* rtl/bbr_pkg.sv */
// Shared constants, types and the lookup function for the 3x3 RGB box blur.
package bbr_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int OROW_W       = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 12;
  localparam int ROW_W        = 12;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int RECIP_W      = 18;
  localparam int RECIP_SHIFT  = 18;
  localparam int CFG_IDX_W    = 1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC
  } bbr_state_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic load_out;
  } bbr_cmd_t;

  typedef struct packed {
    logic skip;
    logic emit;
    logic out_free;
  } bbr_status_t;

  // Reciprocal of 2*n scaled by 2**RECIP_SHIFT and rounded up; exact for
  // every numerator below 2**13.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    begin
      unique case (n)
        CNT_W'(1): r = RECIP_W'(131072);
        CNT_W'(2): r = RECIP_W'(65536);
        CNT_W'(3): r = RECIP_W'(43691);
        CNT_W'(4): r = RECIP_W'(32768);
        CNT_W'(6): r = RECIP_W'(21846);
        CNT_W'(9): r = RECIP_W'(14564);
        default:   r = RECIP_W'(131072);
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/bbr_in_if.sv */
// Input channel carrying one pixel or flush word.
interface bbr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

/* rtl/bbr_out_if.sv */
// Output channel carrying one blurred pixel word.
interface bbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

/* rtl/bbr_ctrl.sv */
// Controller state machine sequencing one word through the blur datapath.
module bbr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bbr_pkg::bbr_status_t status_i,
  output bbr_pkg::bbr_cmd_t    cmd_o
);
  import bbr_pkg::*;

  bbr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !status_i.skip) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (!status_i.emit || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.capture    = 1'b0;
    cmd_o.step       = 1'b0;
    cmd_o.load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOAD: begin
        cmd_o.step = 1'b1;
      end
      ST_CALC: begin
        cmd_o.load_out = status_i.emit && status_i.out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

/* rtl/bbr_datapath.sv */
// Line buffers, window, position counters, sums and divider of the blur.
module bbr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbr_pkg::DIM_W-1:0]          cfg_data_i,
  input  logic                               in_command_i,
  input  logic [bbr_pkg::CH_W-1:0]           in_red_i,
  input  logic [bbr_pkg::CH_W-1:0]           in_green_i,
  input  logic [bbr_pkg::CH_W-1:0]           in_blue_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [bbr_pkg::CH_W-1:0]           out_red_o,
  output logic [bbr_pkg::CH_W-1:0]           out_green_o,
  output logic [bbr_pkg::CH_W-1:0]           out_blue_o,
  output logic                               out_last_o,
  input  bbr_pkg::bbr_cmd_t                  cmd_i,
  output bbr_pkg::bbr_status_t               status_o
);
  import bbr_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [OROW_W-1:0] orow_q, orow_d;
  logic [PIX_W-1:0]  win_q [6];
  logic [PIX_W-1:0]  up_q, lo_q, px_q;
  logic              flush_q;
  logic [PIX_W-1:0]  px_eff;
  logic [PIX_W-1:0]  cols [3][3];
  logic [2:0]        rok, cok;
  logic [1:0]        rcnt, ccnt;
  logic [CNT_W-1:0]  n_cnt;
  logic [SUM_W-1:0]  sum_d [3];
  logic [SUM_W-1:0]  sum_q [3];
  logic [CNT_W-1:0]  n_q;
  logic [RECIP_W-1:0] recip_q;
  logic              emit_d, emit_q, last_d, last_q;
  logic [DIM_W-1:0]  col_inc;
  logic [SUM_W:0]    numer [3];
  logic [SUM_W+RECIP_W:0] prod [3];
  logic [CH_W-1:0]   mean [3];
  logic              out_valid_q;
  logic [CH_W-1:0]   red_q, green_q, blue_q;
  logic              last_out_q;
  logic              restart;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(HEIGHT_LIMIT)) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // The line buffers are read when a word is taken and written back in the next cycle, unless it is a skipped flush.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      up_q    <= upper_mem[col_q];
      lo_q    <= lower_mem[col_q];
      px_q    <= {in_red_i, in_green_i, in_blue_i};
      flush_q <= in_command_i;
    end
    if (cmd_i.step) begin
      upper_mem[col_q] <= lo_q;
      lower_mem[col_q] <= px_eff;
    end
  end

  assign px_eff = (flush_q == CMD_FLUSH || row_q >= h_eff) ? '0 : px_q;

  always_comb begin
    cols[0][0] = win_q[0];
    cols[0][1] = win_q[1];
    cols[0][2] = win_q[2];
    cols[1][0] = win_q[3];
    cols[1][1] = win_q[4];
    cols[1][2] = win_q[5];
    cols[2][0] = up_q;
    cols[2][1] = lo_q;
    cols[2][2] = px_eff;
    rok[0] = orow_q != '0;
    rok[1] = 1'b1;
    rok[2] = ({1'b0, orow_q} + 1'b1) < h_eff;
    cok[0] = ocol_q != '0;
    cok[1] = 1'b1;
    cok[2] = ({1'b0, ocol_q} + 1'b1) < w_eff;
    rcnt = 2'(rok[0]) + 2'(rok[2]) + 2'd1;
    ccnt = 2'(cok[0]) + 2'(cok[2]) + 2'd1;
    n_cnt = CNT_W'(rcnt) * CNT_W'(ccnt);
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (cok[c] && rok[r]) begin
          sum_d[0] = sum_d[0] + SUM_W'(cols[c][r][23:16]);
          sum_d[1] = sum_d[1] + SUM_W'(cols[c][r][15:8]);
          sum_d[2] = sum_d[2] + SUM_W'(cols[c][r][7:0]);
        end
      end
    end
    emit_d = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
    last_d = (({1'b0, orow_q} + 1'b1) == h_eff) && (({1'b0, ocol_q} + 1'b1) == w_eff);
  end

  assign restart = cfg_we_i || (cmd_i.step && emit_d && last_d);
  assign col_inc = {1'b0, col_q} + 1'b1;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (restart) begin
      col_d  = '0;
      row_d  = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (cmd_i.step) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
      if (emit_d) begin
        if (({1'b0, ocol_q} + 1'b1) >= w_eff) begin
          ocol_d = '0;
          orow_d = orow_q + 1'b1;
        end else begin
          ocol_d = ocol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
      emit_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      if (restart) begin
        for (int k = 0; k < 6; k++) begin
          win_q[k] <= '0;
        end
      end else if (cmd_i.step) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= up_q;
        win_q[4] <= lo_q;
        win_q[5] <= px_eff;
      end
      if (cmd_i.step) begin
        emit_q <= emit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      sum_q   <= sum_d;
      n_q     <= n_cnt;
      recip_q <= recip_of(n_cnt);
      last_q  <= last_d;
    end
  end

  // Each mean is floor((2*sum + n) / (2*n)) through a reciprocal multiply.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      numer[k] = {sum_q[k], 1'b0} + (SUM_W+1)'(n_q);
      prod[k]  = (SUM_W+RECIP_W+1)'(numer[k]) * (SUM_W+RECIP_W+1)'(recip_q);
      mean[k]  = prod[k][RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_q      <= mean[0];
      green_q    <= mean[1];
      blue_q     <= mean[2];
      last_out_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_last_o  = last_out_q;

  assign status_o.skip     = (in_command_i == CMD_FLUSH) && row_q == '0 && col_q == '0;
  assign status_o.emit     = emit_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* rtl/box_blur_3x3_rgb.sv */
// Top level of the streaming 3x3 RGB box blur.
//
//   channel   direction  handshake        word
//   in_i      sink       valid / ready    command, red_in, green_in, blue_in
//   out_o     source     valid / ready    red_out, green_out, blue_out, frame_last
//   cfg       write      cfg_we_i         cfg_idx_i, cfg_data_i
//
// Each word goes through a line buffer read, a window update with sums and,
// if it yields a pixel, the reciprocal multiply into the output register.
// A flush word at the start of a frame is taken and gives nothing.
// A finished pixel waits in the output register while the next word is taken;
// the multiply step stalls only while that register is still full.
// Reset is asynchronous and active low; no clearing pass is needed.
module box_blur_3x3_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbr_pkg::DIM_W-1:0]     cfg_data_i,
  bbr_in_if.sink                        in_i,
  bbr_out_if.source                     out_o
);
  import bbr_pkg::*;

  bbr_cmd_t    cmd;
  bbr_status_t status;

  bbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_command_i (in_i.command),
    .in_red_i     (in_i.red_in),
    .in_green_i   (in_i.green_in),
    .in_blue_i    (in_i.blue_in),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_red_o    (out_o.red_out),
    .out_green_o  (out_o.green_out),
    .out_blue_o   (out_o.blue_out),
    .out_last_o   (out_o.frame_last),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
